### design/csia_pkg.sv
// Shared types, constants and codes of the checked signed integer ALU.
package csia_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int DW = DATA_WIDTH;
  localparam int LATENCY = DW + 2;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_REM = 3'd4;
  localparam logic [2:0] CMD_NEG = 3'd5;

  localparam logic [1:0] TRAP_NONE = 2'd0;
  localparam logic [1:0] TRAP_OVF  = 2'd1;
  localparam logic [1:0] TRAP_DIVZ = 2'd2;

  localparam logic [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};

  typedef enum logic [1:0] {
    KIND_EARLY,
    KIND_MUL,
    KIND_DIV,
    KIND_REM
  } kind_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [1:0]         trap_code;
  } result_t;

  // control that rides along the cell chain
  typedef struct packed {
    kind_t          kind;
    logic           na;
    logic           neg;
    logic [DW-1:0]  res;
    logic [1:0]     trap;
  } ctl_t;

  // datapath state handed from cell to cell
  typedef struct packed {
    logic [DW-1:0]   mc;
    logic [DW-1:0]   dv;
    logic [2*DW-1:0] p;
    logic [DW-1:0]   rem;
    logic [DW-1:0]   dq;
  } work_t;

endpackage

### design/csia_front.sv
// Operand decode, add/sub/negate, trap screening and chain load.
module csia_front
  import csia_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  take,
  input  req_t  req,
  output logic  valid,
  output ctl_t  ctl,
  output work_t work
);

  logic [DW-1:0] a, b, ma, mb;
  logic [DW:0]   sum, diff;
  logic          amin;
  ctl_t          ctl_next;
  work_t         work_next;

  always_comb begin
    a    = req.operand_a[DW-1:0];
    b    = req.operand_b[DW-1:0];
    ma   = a[DW-1] ? (~a + 1'b1) : a;
    mb   = b[DW-1] ? (~b + 1'b1) : b;
    sum  = {a[DW-1], a} + {b[DW-1], b};
    diff = {a[DW-1], a} - {b[DW-1], b};
    amin = (a == MIN_VAL);

    ctl_next.kind = KIND_EARLY;
    ctl_next.na   = a[DW-1];
    ctl_next.neg  = a[DW-1] ^ b[DW-1];
    ctl_next.res  = '0;
    ctl_next.trap = TRAP_NONE;
    case (req.cmd)
      CMD_ADD: begin
        if (sum[DW] != sum[DW-1]) ctl_next.trap = TRAP_OVF;
        else ctl_next.res = sum[DW-1:0];
      end
      CMD_SUB: begin
        if (diff[DW] != diff[DW-1]) ctl_next.trap = TRAP_OVF;
        else ctl_next.res = diff[DW-1:0];
      end
      CMD_MUL: ctl_next.kind = KIND_MUL;
      CMD_DIV, CMD_REM: begin
        if (b == '0) begin
          ctl_next.trap = TRAP_DIVZ;
        end else if (amin && b == '1) begin
          ctl_next.trap = TRAP_OVF;
        end else begin
          ctl_next.kind = (req.cmd == CMD_DIV) ? KIND_DIV : KIND_REM;
        end
      end
      CMD_NEG: begin
        if (amin) ctl_next.trap = TRAP_OVF;
        else ctl_next.res = ~a + 1'b1;
      end
      default: ;
    endcase

    work_next.mc  = ma;
    work_next.dv  = mb;
    work_next.p   = {{DW{1'b0}}, mb};
    work_next.rem = '0;
    work_next.dq  = ma;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    ctl  <= ctl_next;
    work <= work_next;
  end

endmodule

### design/csia_cell.sv
// One step of the chain: a shift-add multiply bit and a restoring divide bit.
module csia_cell
  import csia_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  ctl_t  in_ctl,
  input  work_t in_work,
  output logic  valid,
  output ctl_t  ctl,
  output work_t work
);

  logic [DW:0] madd;
  logic [DW:0] sh;
  logic [DW:0] trial;
  logic        ge;
  work_t       work_next;

  always_comb begin
    // multiply: add multiplicand into the high half, then shift right
    madd = {1'b0, in_work.p[2*DW-1:DW]} + (in_work.p[0] ? {1'b0, in_work.mc} : '0);
    // divide: bring in the next dividend bit, trial subtract
    sh    = {in_work.rem, in_work.dq[DW-1]};
    trial = sh - {1'b0, in_work.dv};
    ge    = ~trial[DW];

    work_next.mc  = in_work.mc;
    work_next.dv  = in_work.dv;
    work_next.p   = {madd, in_work.p[DW-1:1]};
    work_next.rem = ge ? trial[DW-1:0] : sh[DW-1:0];
    work_next.dq  = {in_work.dq[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ctl  <= in_ctl;
    work <= work_next;
  end

endmodule

### design/csia_back.sv
// Sign fix-up, multiply range check and result register.
module csia_back
  import csia_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  ctl_t    in_ctl,
  input  work_t   in_work,
  output logic    done,
  output result_t result
);

  logic [DW-1:0] lo, hi, limit, r;
  logic [1:0]    trap;
  result_t       result_next;

  always_comb begin
    lo    = in_work.p[DW-1:0];
    hi    = in_work.p[2*DW-1:DW];
    limit = in_ctl.neg ? MIN_VAL : MAX_VAL;
    r     = in_ctl.res;
    trap  = in_ctl.trap;
    case (in_ctl.kind)
      KIND_MUL: begin
        if (hi != '0 || lo > limit) begin
          trap = TRAP_OVF;
          r    = '0;
        end else begin
          r = in_ctl.neg ? (~lo + 1'b1) : lo;
        end
      end
      KIND_DIV: r = in_ctl.neg ? (~in_work.dq + 1'b1) : in_work.dq;
      KIND_REM: r = in_ctl.na ? (~in_work.rem + 1'b1) : in_work.rem;
      default: ;
    endcase
    result_next.result_value = 64'(signed'(r));
    result_next.trap_code    = trap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

### design/checked_signed_integer_alu_top.sv
// Top level of the checked signed integer ALU: front stage, cell chain, back stage.
//
//  port    dir  kind    meaning
//  req     in   req_t   request: cmd, operand_a, operand_b; taken on start && !busy
//  busy    out  logic   always low, a request may enter every cycle
//  result  out  result_t result_value, trap_code; valid for the one cycle of done
//
// A request can be taken every cycle while start is high. The accepting edge loads the decode
// stage; the request then passes one decode stage, one cell per operand bit and one fix-up
// stage, and done rises with its result.
// The latency is set by the multiply/divide cell chain, one bit per cell.
// Synchronous active-high reset clears all valid flags; payload is not reset.
// The receiver cannot stall, so nothing ever holds back the chain.
module checked_signed_integer_alu_top
  import csia_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  req_t    req,
  output logic    done,
  output result_t result
);

  logic  v   [DW+1];
  ctl_t  c   [DW+1];
  work_t w   [DW+1];

  assign busy = 1'b0;

  csia_front u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (start && !busy),
    .req   (req),
    .valid (v[0]),
    .ctl   (c[0]),
    .work  (w[0])
  );

  for (genvar i = 0; i < DW; i++) begin : g_cell
    csia_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v[i]),
      .in_ctl   (c[i]),
      .in_work  (w[i]),
      .valid    (v[i+1]),
      .ctl      (c[i+1]),
      .work     (w[i+1])
    );
  end

  csia_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v[DW]),
    .in_ctl   (c[DW]),
    .in_work  (w[DW]),
    .done     (done),
    .result   (result)
  );

  a_trap_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.trap_code == TRAP_NONE || result.trap_code == TRAP_OVF ||
              result.trap_code == TRAP_DIVZ))
    else $error("undefined trap code");

  a_trap_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.trap_code != TRAP_NONE |-> result.result_value == 64'sd0)
    else $error("trapped result not zero");

  a_sext: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.result_value[63:DW-1] == '0 || result.result_value[63:DW-1] == '1))
    else $error("result not sign extended");

endmodule

### bench/checked_signed_integer_alu_top_test.sv
// Testbench of the checked signed integer ALU: random and directed requests, scoreboard check.
`timescale 1ns / 1ps

module checked_signed_integer_alu_top_test;
  import csia_pkg::*;

  class alu_scoreboard;
    result_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // exact signed 64-bit ALU with traps
    function result_t compute(req_t r);
      result_t o;
      logic signed [127:0] wide;
      logic signed [63:0] a;
      logic signed [63:0] b;
      a = r.operand_a;
      b = r.operand_b;
      o.result_value = '0;
      o.trap_code = TRAP_NONE;
      case (r.cmd)
        CMD_ADD: wide = 128'(a) + 128'(b);
        CMD_SUB: wide = 128'(a) - 128'(b);
        CMD_MUL: wide = 128'(a) * 128'(b);
        CMD_NEG: wide = -128'(a);
        CMD_DIV, CMD_REM: begin
          if (b == 0) o.trap_code = TRAP_DIVZ;
          else if (a == MIN_VAL && b == -64'sd1) o.trap_code = TRAP_OVF;
          else if (r.cmd == CMD_DIV) o.result_value = a / b;
          else o.result_value = a % b;
          return o;
        end
        default: return o;
      endcase
      if (wide[127:63] != {65{wide[63]}})
        o.trap_code = TRAP_OVF;
      else o.result_value = wide[63:0];
      return o;
    endfunction

    function void note_request(req_t r);
      pending.push_back(compute(r));
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      want = pending.pop_front();
      if (got.result_value !== want.result_value)
        report($sformatf("value %0d want %0d", got.result_value, want.result_value));
      if (got.trap_code !== want.trap_code)
        report($sformatf("trap %0d want %0d", got.trap_code, want.trap_code));
    endtask
  endclass

  logic clk, rst, start, busy, done;
  req_t req;
  result_t result;
  alu_scoreboard sb;
  longint unsigned cycles;

  checked_signed_integer_alu_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .result(result)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_result(result);
    if (cycles > 400000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function logic [63:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return MIN_VAL;
      1: return MAX_VAL;
      2: return -64'sd1;
      3: return 64'(signed'($urandom_range(0, 20)) - 10);
      4: return {32'(0), $urandom()} >> $urandom_range(0, 31);
      5: return {{32{1'b1}}, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // hold start for one accepted request, then drop it for a random gap, if any
  task send(logic [2:0] c, logic [63:0] a, logic [63:0] b, bit gap);
    int wait_n;
    req.cmd <= c;
    req.operand_a <= a;
    req.operand_b <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request('{c, a, b});
    wait_n = gap ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (wait_n > 0) begin
      start <= 1'b0;
      repeat (wait_n) @(negedge clk);
    end
  endtask

  // called at a falling edge: stop sending and wait for every result
  task drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [63:0] edges[5];
    bit gaps;
    sb = new();
    cycles = 0;
    rst = 1;
    start = 0;
    req = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;
    edges = '{MIN_VAL, MAX_VAL, -64'sd1, 64'd0, 64'd1};
    for (int c = 0; c <= 7; c++) begin
      send(3'(c), MIN_VAL, -64'sd1, 0);
      send(3'(c), MAX_VAL, MAX_VAL, 0);
      send(3'(c), edges[c % 5], 64'd0, 0);
    end
    drain();
    for (int i = 0; i < 1900; i++) begin
      if (i % 300 == 0) gaps = ~gaps;
      if (i == 950) drain();
      send(3'($urandom_range(0, 7)), pick_operand(), pick_operand(), gaps);
    end
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

### checked_signed_integer_alu_top.f
design/csia_pkg.sv
design/csia_front.sv
design/csia_cell.sv
design/csia_back.sv
design/checked_signed_integer_alu_top.sv
bench/checked_signed_integer_alu_top_test.sv
